### design/srp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package srp_pkg;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } srp_in_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic [15:0] dest_port;
    logic [1:0]  proto_kind;
    logic [1:0]  addr_kind;
    logic        last;
  } srp_out_t;

  localparam int MAX_RESULTS = 5;
  localparam int FIFO_DEPTH  = 16;
  localparam int STALL_LEVEL = FIFO_DEPTH - 2 * MAX_RESULTS;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int LVL_W       = $clog2(FIFO_DEPTH + 1);
  localparam int PTR_W       = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [CNT_W-1:0]              count;
    srp_out_t [MAX_RESULTS-1:0]    item;
  } srp_burst_t;

  localparam logic [1:0] K_REPLY  = 2'd0;
  localparam logic [1:0] K_ADDR   = 2'd1;
  localparam logic [1:0] K_DONE   = 2'd2;
  localparam logic [1:0] K_REJECT = 2'd3;

  localparam logic [1:0] PROTO_S4  = 2'd0;
  localparam logic [1:0] PROTO_S4A = 2'd1;
  localparam logic [1:0] PROTO_S5  = 2'd2;

  localparam logic [1:0] ADDR_IPV4 = 2'd0;
  localparam logic [1:0] ADDR_NAME = 2'd1;
  localparam logic [1:0] ADDR_IPV6 = 2'd2;

  localparam logic [7:0] VER_S4        = 8'h04;
  localparam logic [7:0] VER_S5        = 8'h05;
  localparam logic [7:0] CMD_CONNECT   = 8'h01;
  localparam logic [7:0] ATYP_IPV4     = 8'h01;
  localparam logic [7:0] ATYP_NAME     = 8'h03;
  localparam logic [7:0] ATYP_IPV6     = 8'h04;
  localparam logic [7:0] METHOD_NOAUTH = 8'h00;
  localparam logic [7:0] NUL_BYTE      = 8'h00;
  localparam logic [7:0] IPV4_LEN      = 8'd4;
  localparam logic [7:0] IPV6_LEN      = 8'd16;
  localparam logic [7:0] PORT_LEN      = 8'd2;
  localparam logic [7:0] MAX_NAME      = 8'd255;

endpackage
`default_nettype wire

### design/socks_request_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir | Handshake          | Payload
// in_     | in  | in_valid/in_stall  | srp_in_t  (req_type, rx_byte)
// out_    | out | out_valid/out_stall| srp_out_t (kind, byte, port, proto, addr, last)
// One byte is accepted per cycle, while in_stall is low, into an input register;
// the parser step runs in the next cycle and writes 0..5 results into a 16-entry
// result queue. Results leave the queue one per cycle while out_stall is low;
// in_stall rises once the queue holds more than 6.
// Reset (rst_n low, synchronous) returns to the version-byte state and empties
// the queue; out_stall only backs up the queue and never drops a result.
module socks_request_parser (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  srp_pkg::srp_in_t   in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output srp_pkg::srp_out_t  out_data
);
  import srp_pkg::*;

  typedef enum logic [4:0] {
    ST_VER, ST_4CMD, ST_4PORT, ST_4IP, ST_4USER, ST_4NAME,
    ST_5NMETH, ST_5METH, ST_5RVER, ST_5RCMD, ST_5RSV, ST_5ATYP,
    ST_5NLEN, ST_5ADDR, ST_5PORT, ST_DONE, ST_DEAD
  } state_t;

  state_t      state_r, state_nxt;
  logic [7:0]  byte_count_r, byte_count_nxt;
  logic [7:0]  methods_left_r, methods_left_nxt;
  logic        no_auth_r, no_auth_nxt;
  logic [15:0] port_r, port_nxt;
  logic [31:0] ipv4_r, ipv4_nxt;
  logic [7:0]  name_left_r, name_left_nxt;
  logic [1:0]  proto_r, proto_nxt;
  logic [1:0]  addr_r, addr_nxt;

  logic        pend_v_r;
  srp_in_t     pend_r;
  logic        in_accept;
  logic [LVL_W-1:0] level;
  srp_burst_t  burst;
  logic [7:0]  b;
  logic [7:0]  count_inc;

  function automatic srp_out_t mk_result(logic [1:0] kind, logic [7:0] val,
                                         logic [15:0] port, logic [1:0] proto,
                                         logic [1:0] addr);
    srp_out_t r;
    r.out_kind   = kind;
    r.out_byte   = val;
    r.dest_port  = port;
    r.proto_kind = proto;
    r.addr_kind  = addr;
    r.last       = 1'b0;
    return r;
  endfunction

  assign in_stall  = (level > LVL_W'(STALL_LEVEL));
  assign in_accept = in_valid & ~in_stall;
  assign b         = pend_r.rx_byte;
  assign count_inc = byte_count_r + 8'd1;

  always_comb begin
    state_nxt        = state_r;
    byte_count_nxt   = byte_count_r;
    methods_left_nxt = methods_left_r;
    no_auth_nxt      = no_auth_r;
    port_nxt         = port_r;
    ipv4_nxt         = ipv4_r;
    name_left_nxt    = name_left_r;
    proto_nxt        = proto_r;
    addr_nxt         = addr_r;
    burst.count      = '0;
    for (int k = 0; k < MAX_RESULTS; k++) begin
      burst.item[k] = mk_result(K_REJECT, 8'h00, 16'h0000, proto_r, addr_r);
    end

    if (pend_v_r) begin
      if (pend_r.req_type) begin
        state_nxt        = ST_VER;
        byte_count_nxt   = '0;
        methods_left_nxt = '0;
        no_auth_nxt      = 1'b0;
        port_nxt         = '0;
        ipv4_nxt         = '0;
        name_left_nxt    = '0;
        proto_nxt        = PROTO_S4;
        addr_nxt         = ADDR_IPV4;
      end else begin
        unique case (state_r)
          ST_VER: begin
            if (b == VER_S4) begin
              proto_nxt = PROTO_S4;
              state_nxt = ST_4CMD;
            end else if (b == VER_S5) begin
              proto_nxt = PROTO_S5;
              state_nxt = ST_5NMETH;
            end else begin
              state_nxt   = ST_DEAD;
              burst.count = CNT_W'(1);
            end
          end
          ST_4CMD: begin
            if (b == CMD_CONNECT) begin
              state_nxt      = ST_4PORT;
              byte_count_nxt = '0;
            end else begin
              state_nxt   = ST_DEAD;
              burst.count = CNT_W'(1);
            end
          end
          ST_4PORT: begin
            port_nxt       = {port_r[7:0], b};
            byte_count_nxt = count_inc;
            if (count_inc >= PORT_LEN) begin
              byte_count_nxt = '0;
              state_nxt      = ST_4IP;
            end
          end
          ST_4IP: begin
            ipv4_nxt       = {ipv4_r[23:0], b};
            byte_count_nxt = count_inc;
            if (count_inc >= IPV4_LEN) begin
              byte_count_nxt = '0;
              state_nxt      = ST_4USER;
              if (ipv4_nxt[31:8] == 24'd0 && ipv4_nxt[7:0] != 8'd0) begin
                proto_nxt = PROTO_S4A;
                addr_nxt  = ADDR_NAME;
              end else begin
                proto_nxt = PROTO_S4;
                addr_nxt  = ADDR_IPV4;
              end
            end
          end
          ST_4USER: begin
            if (b == NUL_BYTE) begin
              if (proto_r == PROTO_S4A) begin
                byte_count_nxt = '0;
                state_nxt      = ST_4NAME;
              end else begin
                state_nxt     = ST_DONE;
                burst.count   = CNT_W'(5);
                burst.item[0] = mk_result(K_ADDR, ipv4_r[31:24], 16'h0000, proto_r, addr_r);
                burst.item[1] = mk_result(K_ADDR, ipv4_r[23:16], 16'h0000, proto_r, addr_r);
                burst.item[2] = mk_result(K_ADDR, ipv4_r[15:8], 16'h0000, proto_r, addr_r);
                burst.item[3] = mk_result(K_ADDR, ipv4_r[7:0], 16'h0000, proto_r, addr_r);
                burst.item[4] = mk_result(K_DONE, 8'h00, port_r, proto_r, addr_r);
              end
            end
          end
          ST_4NAME: begin
            burst.count = CNT_W'(1);
            if (b == NUL_BYTE) begin
              state_nxt     = ST_DONE;
              burst.item[0] = mk_result(K_DONE, 8'h00, port_r, proto_r, addr_r);
            end else if (byte_count_r >= MAX_NAME) begin
              state_nxt = ST_DEAD;
            end else begin
              byte_count_nxt = count_inc;
              burst.item[0]  = mk_result(K_ADDR, b, 16'h0000, proto_r, addr_r);
            end
          end
          ST_5NMETH: begin
            if (b == 8'd0) begin
              state_nxt   = ST_DEAD;
              burst.count = CNT_W'(1);
            end else begin
              methods_left_nxt = b;
              no_auth_nxt      = 1'b0;
              state_nxt        = ST_5METH;
            end
          end
          ST_5METH: begin
            no_auth_nxt      = no_auth_r | (b == METHOD_NOAUTH);
            methods_left_nxt = methods_left_r - 8'd1;
            if (methods_left_nxt == 8'd0) begin
              if (no_auth_nxt) begin
                state_nxt     = ST_5RVER;
                burst.count   = CNT_W'(2);
                burst.item[0] = mk_result(K_REPLY, VER_S5, 16'h0000, proto_r, addr_r);
                burst.item[1] = mk_result(K_REPLY, METHOD_NOAUTH, 16'h0000, proto_r, addr_r);
              end else begin
                state_nxt   = ST_DEAD;
                burst.count = CNT_W'(1);
              end
            end
          end
          ST_5RVER: begin
            if (b == VER_S5) begin
              state_nxt = ST_5RCMD;
            end else begin
              state_nxt   = ST_DEAD;
              burst.count = CNT_W'(1);
            end
          end
          ST_5RCMD: begin
            if (b == CMD_CONNECT) begin
              state_nxt = ST_5RSV;
            end else begin
              state_nxt   = ST_DEAD;
              burst.count = CNT_W'(1);
            end
          end
          ST_5RSV: begin
            state_nxt = ST_5ATYP;
          end
          ST_5ATYP: begin
            byte_count_nxt = '0;
            port_nxt       = '0;
            if (b == ATYP_IPV4) begin
              addr_nxt      = ADDR_IPV4;
              name_left_nxt = IPV4_LEN;
              state_nxt     = ST_5ADDR;
            end else if (b == ATYP_IPV6) begin
              addr_nxt      = ADDR_IPV6;
              name_left_nxt = IPV6_LEN;
              state_nxt     = ST_5ADDR;
            end else if (b == ATYP_NAME) begin
              addr_nxt  = ADDR_NAME;
              state_nxt = ST_5NLEN;
            end else begin
              state_nxt   = ST_DEAD;
              burst.count = CNT_W'(1);
            end
          end
          ST_5NLEN: begin
            name_left_nxt = b;
            state_nxt     = (b == 8'd0) ? ST_5PORT : ST_5ADDR;
          end
          ST_5ADDR: begin
            burst.count   = CNT_W'(1);
            burst.item[0] = mk_result(K_ADDR, b, 16'h0000, proto_r, addr_r);
            name_left_nxt = name_left_r - 8'd1;
            if (name_left_nxt == 8'd0) begin
              state_nxt = ST_5PORT;
            end
          end
          ST_5PORT: begin
            port_nxt       = {port_r[7:0], b};
            byte_count_nxt = count_inc;
            if (count_inc >= PORT_LEN) begin
              state_nxt     = ST_DONE;
              burst.count   = CNT_W'(1);
              burst.item[0] = mk_result(K_DONE, 8'h00, port_nxt, proto_r, addr_r);
            end
          end
          ST_DONE, ST_DEAD: begin
          end
          default: begin
            state_nxt = ST_DEAD;
          end
        endcase
      end
    end

    // mark the final result of this transaction
    for (int k = 0; k < MAX_RESULTS; k++) begin
      burst.item[k].last = (CNT_W'(k + 1) == burst.count);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r       <= 1'b0;
      state_r        <= ST_VER;
      byte_count_r   <= '0;
      methods_left_r <= '0;
      no_auth_r      <= 1'b0;
      port_r         <= '0;
      ipv4_r         <= '0;
      name_left_r    <= '0;
      proto_r        <= PROTO_S4;
      addr_r         <= ADDR_IPV4;
    end else begin
      pend_v_r       <= in_accept;
      state_r        <= state_nxt;
      byte_count_r   <= byte_count_nxt;
      methods_left_r <= methods_left_nxt;
      no_auth_r      <= no_auth_nxt;
      port_r         <= port_nxt;
      ipv4_r         <= ipv4_nxt;
      name_left_r    <= name_left_nxt;
      proto_r        <= proto_nxt;
      addr_r         <= addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pend_r <= in_data;
    end
  end

  srp_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_burst  (burst),
    .level     (level),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_new_conn_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_v_r && pend_r.req_type) |=> (state_r == ST_VER && proto_r == PROTO_S4))
    else $error("new connection did not restart the parser");

  a_ended_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_v_r && !pend_r.req_type && (state_r == ST_DONE || state_r == ST_DEAD))
      |-> (burst.count == '0))
    else $error("result produced after request ended");

  a_reject_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (burst.count == CNT_W'(1) && burst.item[0].out_kind == K_REJECT)
      |=> (state_r == ST_DEAD))
    else $error("reject did not stop the parser");

  a_idle_no_burst: assert property (@(posedge clk) disable iff (!rst_n)
    !pend_v_r |-> (burst.count == '0 && state_nxt == state_r))
    else $error("parser advanced without a transaction");

endmodule
`default_nettype wire

### design/srp_result_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module srp_result_fifo (
  input  wire                        clk,
  input  wire                        rst_n,
  input  srp_pkg::srp_burst_t        wr_burst,
  output logic [srp_pkg::LVL_W-1:0]  level,
  output logic                       out_valid,
  input  wire                        out_stall,
  output srp_pkg::srp_out_t          out_data
);
  import srp_pkg::*;

  srp_out_t         mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic             rd_en;

  assign out_valid = (level_r != '0);
  assign rd_en     = out_valid & ~out_stall;
  assign out_data  = mem_r[rd_ptr_r];
  assign level     = level_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(wr_burst.count);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(rd_en);
    level_nxt  = level_r + LVL_W'(wr_burst.count) - LVL_W'(rd_en);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (CNT_W'(k) < wr_burst.count) begin
        mem_r[wr_ptr_r + PTR_W'(k)] <= wr_burst.item[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LVL_W'(FIFO_DEPTH))
    else $error("result queue level out of range");

  a_room_for_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_burst.count != '0) |-> (level_r <= LVL_W'(FIFO_DEPTH - MAX_RESULTS)))
    else $error("result burst written without room");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (level_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with unequal pointers");

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import srp_pkg::*;

  typedef enum logic [4:0] {
    PS_VER, PS_4CMD, PS_4PORT, PS_4IP, PS_4USER, PS_4NAME, PS_5NMETH, PS_5METH,
    PS_5RVER, PS_5RCMD, PS_5RSV, PS_5ATYP, PS_5NLEN, PS_5ADDR, PS_5PORT,
    PS_DONE, PS_DEAD
  } parse_st_t;

  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 120;
  localparam int SETTLE      = 8;
  localparam int PHASE_ITEMS = 78;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  srp_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  srp_out_t out_data;

  srp_in_t  byte_q[$];
  srp_in_t  req_q[$];
  srp_out_t parsed_q[$];
  srp_out_t step_q[$];
  srp_out_t want;

  int   queued_n      = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic long_hold_req = 1'b0;
  int   hold_left     = 0;
  logic hold_used     = 1'b0;
  int   mismatch_n    = 0;
  int   quiet_n       = 0;

  parse_st_t   ps;
  logic [7:0]  cnt;
  logic [7:0]  meth_left;
  logic        noauth;
  logic [15:0] port_acc;
  logic [31:0] ip_acc;
  logic [7:0]  name_left;
  logic [1:0]  proto;
  logic [1:0]  addr;

  socks_request_parser i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic string show_item(srp_out_t r);
    return $sformatf("kind %0d byte %h port %h proto %0d addr %0d last %0d",
                     r.out_kind, r.out_byte, r.dest_port, r.proto_kind,
                     r.addr_kind, r.last);
  endfunction

  function automatic void clear_parser();
    ps        = PS_VER;
    cnt       = '0;
    meth_left = '0;
    noauth    = 1'b0;
    port_acc  = '0;
    ip_acc    = '0;
    name_left = '0;
    proto     = PROTO_S4;
    addr      = ADDR_IPV4;
  endfunction

  function automatic void add_result(logic [1:0] kind, logic [7:0] data, logic [15:0] port);
    srp_out_t r;
    r.out_kind   = kind;
    r.out_byte   = data;
    r.dest_port  = port;
    r.proto_kind = proto;
    r.addr_kind  = addr;
    r.last       = 1'b0;
    step_q = {step_q, r};
  endfunction

  function automatic void reject_req();
    ps = PS_DEAD;
    add_result(K_REJECT, 8'h00, 16'h0000);
  endfunction

  function automatic void finish_req();
    ps = PS_DONE;
    add_result(K_DONE, 8'h00, port_acc);
  endfunction

  function automatic void parse_step(srp_in_t t);
    logic [7:0] b;
    int i;
    b = t.rx_byte;
    step_q.delete();
    if (t.req_type) begin
      clear_parser();
      return;
    end
    case (ps)
      PS_VER: begin
        if (b == VER_S4) begin
          proto = PROTO_S4;
          ps    = PS_4CMD;
        end else if (b == VER_S5) begin
          proto = PROTO_S5;
          ps    = PS_5NMETH;
        end else begin
          reject_req();
        end
      end
      PS_4CMD: begin
        if (b == CMD_CONNECT) begin
          ps  = PS_4PORT;
          cnt = '0;
        end else begin
          reject_req();
        end
      end
      PS_4PORT: begin
        port_acc = {port_acc[7:0], b};
        cnt++;
        if (cnt >= PORT_LEN) begin
          cnt = '0;
          ps  = PS_4IP;
        end
      end
      PS_4IP: begin
        ip_acc = {ip_acc[23:0], b};
        cnt++;
        if (cnt >= IPV4_LEN) begin
          cnt = '0;
          if (ip_acc[31:8] == '0 && ip_acc[7:0] != '0) begin
            proto = PROTO_S4A;
            addr  = ADDR_NAME;
          end else begin
            proto = PROTO_S4;
            addr  = ADDR_IPV4;
          end
          ps = PS_4USER;
        end
      end
      PS_4USER: begin
        if (b == NUL_BYTE) begin
          if (proto == PROTO_S4A) begin
            cnt = '0;
            ps  = PS_4NAME;
          end else begin
            for (i = 3; i >= 0; i--) add_result(K_ADDR, ip_acc[8*i +: 8], 16'h0000);
            finish_req();
          end
        end
      end
      PS_4NAME: begin
        if (b == NUL_BYTE) begin
          finish_req();
        end else if (cnt >= MAX_NAME) begin
          reject_req();
        end else begin
          cnt++;
          add_result(K_ADDR, b, 16'h0000);
        end
      end
      PS_5NMETH: begin
        if (b == 8'h00) begin
          reject_req();
        end else begin
          meth_left = b;
          noauth    = 1'b0;
          ps        = PS_5METH;
        end
      end
      PS_5METH: begin
        if (b == METHOD_NOAUTH) noauth = 1'b1;
        meth_left--;
        if (meth_left == '0) begin
          if (noauth) begin
            add_result(K_REPLY, VER_S5, 16'h0000);
            add_result(K_REPLY, METHOD_NOAUTH, 16'h0000);
            ps = PS_5RVER;
          end else begin
            reject_req();
          end
        end
      end
      PS_5RVER: begin
        if (b == VER_S5) ps = PS_5RCMD;
        else reject_req();
      end
      PS_5RCMD: begin
        if (b == CMD_CONNECT) ps = PS_5RSV;
        else reject_req();
      end
      PS_5RSV: begin
        ps = PS_5ATYP;
      end
      PS_5ATYP: begin
        cnt      = '0;
        port_acc = '0;
        if (b == ATYP_IPV4) begin
          addr      = ADDR_IPV4;
          name_left = IPV4_LEN;
          ps        = PS_5ADDR;
        end else if (b == ATYP_IPV6) begin
          addr      = ADDR_IPV6;
          name_left = IPV6_LEN;
          ps        = PS_5ADDR;
        end else if (b == ATYP_NAME) begin
          addr = ADDR_NAME;
          ps   = PS_5NLEN;
        end else begin
          reject_req();
        end
      end
      PS_5NLEN: begin
        name_left = b;
        ps        = (b == 8'h00) ? PS_5PORT : PS_5ADDR;
      end
      PS_5ADDR: begin
        add_result(K_ADDR, b, 16'h0000);
        name_left--;
        if (name_left == '0) ps = PS_5PORT;
      end
      PS_5PORT: begin
        port_acc = {port_acc[7:0], b};
        cnt++;
        if (cnt >= PORT_LEN) finish_req();
      end
      default: begin
      end
    endcase
    if (step_q.size() != 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[k]) parsed_q = {parsed_q, step_q[k]};
  endfunction

  task automatic put(logic r, logic [7:0] b);
    srp_in_t t;
    t.req_type = r;
    t.rx_byte  = b;
    byte_q = {byte_q, t};
    queued_n++;
  endtask

  task automatic put_new();
    put(1'b1, 8'($urandom));
  endtask

  function automatic void stage(logic r, logic [7:0] v);
    srp_in_t t;
    t.req_type = r;
    t.rx_byte  = v;
    req_q = {req_q, t};
  endfunction

  task automatic queue_request();
    int          pick;
    int          n;
    int          pos;
    int          i;
    logic [31:0] ip;
    req_q.delete();
    pick = $urandom_range(99);
    if ($urandom_range(9) != 0) stage(1'b1, 8'($urandom));
    if (pick < 30) begin
      ip = $urandom;
      if ($urandom_range(7) == 0) ip = '0;
      if (ip[31:8] == '0 && ip[7:0] != '0) ip[31] = 1'b1;
      stage(1'b0, VER_S4);
      stage(1'b0, CMD_CONNECT);
      repeat (PORT_LEN) stage(1'b0, 8'($urandom));
      for (i = 3; i >= 0; i--) stage(1'b0, ip[8*i +: 8]);
      repeat ($urandom_range(3)) stage(1'b0, 8'($urandom_range(1, 255)));
      stage(1'b0, NUL_BYTE);
    end else if (pick < 50) begin
      stage(1'b0, VER_S4);
      stage(1'b0, CMD_CONNECT);
      repeat (PORT_LEN) stage(1'b0, 8'($urandom));
      repeat (3) stage(1'b0, NUL_BYTE);
      stage(1'b0, 8'($urandom_range(1, 255)));
      repeat ($urandom_range(2)) stage(1'b0, 8'($urandom_range(1, 255)));
      stage(1'b0, NUL_BYTE);
      repeat ($urandom_range(6)) stage(1'b0, 8'($urandom_range(1, 255)));
      stage(1'b0, NUL_BYTE);
    end else if (pick < 85) begin
      n   = $urandom_range(1, 4);
      pos = ($urandom_range(7) == 0) ? n : $urandom_range(n - 1);
      stage(1'b0, VER_S5);
      stage(1'b0, 8'(n));
      for (i = 0; i < n; i++) begin
        stage(1'b0, (i == pos) ? METHOD_NOAUTH : 8'($urandom_range(1, 255)));
      end
      stage(1'b0, VER_S5);
      stage(1'b0, CMD_CONNECT);
      stage(1'b0, 8'($urandom));
      case ($urandom_range(2))
        0: begin
          stage(1'b0, ATYP_IPV4);
          repeat (IPV4_LEN) stage(1'b0, 8'($urandom));
        end
        1: begin
          n = $urandom_range(6);
          stage(1'b0, ATYP_NAME);
          stage(1'b0, 8'(n));
          repeat (n) stage(1'b0, 8'($urandom));
        end
        default: begin
          stage(1'b0, ATYP_IPV6);
          repeat (IPV6_LEN) stage(1'b0, 8'($urandom));
        end
      endcase
      repeat (PORT_LEN) stage(1'b0, 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 6)) stage(1'b0, 8'($urandom));
    end
    if ($urandom_range(9) == 0 && req_q.size() != 0) begin
      i = $urandom_range(req_q.size() - 1);
      req_q[i].rx_byte = 8'($urandom);
    end
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 2)) stage(1'b0, 8'($urandom));
    end
    foreach (req_q[k]) put(req_q[k].req_type, req_q[k].rx_byte);
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || in_valid || parsed_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      clear_parser();
    end else begin
      if (in_valid && !in_stall) parse_step(in_data);
      if (!(in_valid && in_stall)) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= byte_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (parsed_q.size() == 0) begin
          if (mismatch_n < 10)
            $display("unexpected transaction: %s", show_item(out_data));
          mismatch_n++;
        end else begin
          want = parsed_q.pop_front();
          if (out_data !== want) begin
            if (mismatch_n < 10) begin
              $display("mismatch at %0t: expected %s", $realtime, show_item(want));
              $display("                  actual %s", show_item(out_data));
            end
            mismatch_n++;
          end
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (long_hold_req && !hold_used) begin
        out_stall <= 1'b1;
        hold_left <= LONG_HOLD;
        hold_used <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_n <= 0;
    end else if (quiet_n >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_n <= quiet_n + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 16;
    recv_idle_pct = 69;
    put_new(); put(1'b0, 8'hFF); put(1'b0, NUL_BYTE);
    put_new(); put(1'b0, VER_S4); put(1'b0, 8'h02);
    put_new(); put(1'b0, VER_S5); put(1'b0, 8'h00);
    put_new(); put(1'b0, VER_S5); put(1'b0, 8'd2); put(1'b0, 8'h01); put(1'b0, 8'hFF);
    put_new(); put(1'b0, VER_S5); put(1'b0, 8'd1); put(1'b0, METHOD_NOAUTH);
    put(1'b0, VER_S5); put(1'b0, CMD_CONNECT); put(1'b0, 8'hFF); put(1'b0, 8'h07);
    put_new(); put(1'b0, VER_S4); put(1'b0, CMD_CONNECT);
    repeat (6) put(1'b0, 8'hFF);
    put(1'b0, NUL_BYTE); put(1'b0, 8'hAB);
    queued_n = 0;
    while (queued_n < PHASE_ITEMS) queue_request();
    wait_drained();

    send_idle_pct = 69;
    recv_idle_pct = 16;
    queued_n = 0;
    while (queued_n < PHASE_ITEMS) queue_request();
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queued_n = 0;
    while (queued_n < PHASE_ITEMS) queue_request();
    long_hold_req = 1'b1;
    wait_drained();

    mismatch_n += parsed_q.size();
    if (mismatch_n == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

### sim.f
design/srp_pkg.sv
design/srp_result_fifo.sv
design/socks_request_parser.sv
tb/tb.sv
